// ----- rtl/spectrogram_level_colormap_top_macros.svh -----
// Assertion macros; clock clk, synchronous reset rst
`ifndef SPECTROGRAM_LEVEL_COLORMAP_TOP_MACROS_SVH
`define SPECTROGRAM_LEVEL_COLORMAP_TOP_MACROS_SVH

// same-cycle implication
`define SCM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/spec_cmap_pkg.sv -----
`default_nettype none

package spec_cmap_pkg;

  typedef struct packed {
    logic signed [15:0] level_db;
    logic [7:0]         column;
    logic [7:0]         bin_row;
  } cell_beat_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] pixel_index;
  } pixel_beat_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CEILING = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BINS    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES  = 3'd4;

  localparam logic [1:0] PAL_GRAY   = 2'd0;
  localparam logic [1:0] PAL_INVERT = 2'd1;
  localparam logic [1:0] PAL_HEAT   = 2'd2;

  localparam logic [15:0] FLOOR_RESET   = 16'hA600;  // -23040
  localparam logic [15:0] CEILING_RESET = 16'h0000;
  localparam logic [1:0]  PALETTE_RESET = PAL_GRAY;
  localparam logic [8:0]  BINS_RESET    = 9'd256;
  localparam logic [8:0]  FRAMES_RESET  = 9'd0;

  localparam logic [16:0] ONE_Q16       = 17'h10000;
  localparam int          FADE_SPAN_Q16 = 22938;
  localparam logic [15:0] EMPTY_RANGE   = 16'd256;

  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = 6;

  localparam logic [1:0] SEG_BLUE   = 2'd0;
  localparam logic [1:0] SEG_CYAN   = 2'd1;
  localparam logic [1:0] SEG_GREEN  = 2'd2;
  localparam logic [1:0] SEG_YELLOW = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/spectrogram_level_colormap_top.sv -----
// Channel  Direction  Handshake             Payload
// cell     in         cell_valid/stall      cell_beat_t: level_db, column, bin_row
// pixel    out        pixel_valid/stall     pixel_beat_t: red, green, blue, pixel_index
// cfg      in         cfg_valid/ready       cfg_index (3 bit), cfg_data (16 bit)
//
// One cell per clock while cell_stall is low; six register stages, s1 to s5
// and the output register, lie between an accepted cell and its pixel beat.
// A floor or ceiling write, and reset, start a bit-serial ceiling reciprocal:
// cell_stall stays high through one load step and 33 divide steps.
// rst is synchronous, active high; it resets control and config registers.
// The pipeline advances as a whole; a stalled pixel beat holds every stage.
`default_nettype none

module spectrogram_level_colormap_top #(
  parameter int HISTORY_COLUMNS = 256,
  parameter int MAX_BINS        = 256
) (
  input  wire                                           clk,
  input  wire                                           rst,
  input  wire                                           cell_valid,
  output logic                                          cell_stall,
  input  wire spec_cmap_pkg::cell_beat_t                cell_payload,
  output logic                                          pixel_valid,
  input  wire                                           pixel_stall,
  output spec_cmap_pkg::pixel_beat_t                    pixel,
  input  wire                                           cfg_valid,
  output logic                                          cfg_ready,
  input  wire [spec_cmap_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  wire [spec_cmap_pkg::CFG_DATA_W-1:0]           cfg_data
);

`include "spectrogram_level_colormap_top_macros.svh"

  localparam logic [15:0] HIST_W  = 16'(HISTORY_COLUMNS);
  localparam logic [15:0] BINS_W  = 16'(MAX_BINS);
  localparam logic [spec_cmap_pkg::DIV_CNT_W-1:0] DIV_LAST =
    spec_cmap_pkg::DIV_CNT_W'(spec_cmap_pkg::DIV_STEPS - 1);

  // configuration registers
  logic [15:0] floor_level;
  logic [15:0] ceiling_level;
  logic [1:0]  palette_select;
  logic [8:0]  bins_in_use;
  logic [8:0]  valid_frames;

  logic cfg_write;
  logic level_write;

  assign cfg_ready   = 1'b1;
  assign cfg_write   = cfg_valid && cfg_ready;
  assign level_write = cfg_write &&
    ((cfg_index == spec_cmap_pkg::CFG_FLOOR) || (cfg_index == spec_cmap_pkg::CFG_CEILING));

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_level    <= spec_cmap_pkg::FLOOR_RESET;
      ceiling_level  <= spec_cmap_pkg::CEILING_RESET;
      palette_select <= spec_cmap_pkg::PALETTE_RESET;
      bins_in_use    <= spec_cmap_pkg::BINS_RESET;
      valid_frames   <= spec_cmap_pkg::FRAMES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        spec_cmap_pkg::CFG_FLOOR:   floor_level    <= cfg_data[15:0];
        spec_cmap_pkg::CFG_CEILING: ceiling_level  <= cfg_data[15:0];
        spec_cmap_pkg::CFG_PALETTE: palette_select <= cfg_data[1:0];
        spec_cmap_pkg::CFG_BINS:    bins_in_use    <= cfg_data[8:0];
        spec_cmap_pkg::CFG_FRAMES:  valid_frames   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // ceiling reciprocal ceil(2^32 / range), restoring divider, one bit a cycle
  logic [16:0] range_s;
  logic [15:0] range_div;
  logic        div_pending;
  logic        div_run;
  logic [15:0] div_r;
  logic [15:0] div_rem;
  logic [32:0] div_q;
  logic [spec_cmap_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [32:0] recip;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic        div_busy;

  assign range_s   = {ceiling_level[15], ceiling_level} - {floor_level[15], floor_level};
  assign range_div = (range_s[16] || (range_s == 17'd0)) ? spec_cmap_pkg::EMPTY_RANGE
                                                        : range_s[15:0];
  assign rem_sh    = {div_rem, div_q[32]};
  assign rem_ge    = rem_sh >= {1'b0, div_r};
  assign div_busy  = div_pending || div_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_pending <= 1'b1;
      div_run     <= 1'b0;
    end else begin
      if (level_write) begin
        div_pending <= 1'b1;
      end else if (div_pending) begin
        div_pending <= 1'b0;
      end
      if (div_pending) begin
        div_run <= 1'b1;
      end else if (div_run && (div_cnt == DIV_LAST)) begin
        div_run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_pending) begin
      div_r   <= range_div;
      div_rem <= 16'd0;
      div_q   <= 33'h1_0000_0000 + 33'(range_div) - 33'd1;
      div_cnt <= '0;
    end else if (div_run) begin
      div_rem <= rem_ge ? 16'(rem_sh - {1'b0, div_r}) : rem_sh[15:0];
      div_q   <= {div_q[31:0], rem_ge};
      div_cnt <= div_cnt + 1'b1;
      if (div_cnt == DIV_LAST) begin
        recip <= {div_q[31:0], rem_ge};
      end
    end
  end

  // fade per column, worked out at elaboration
  logic [16:0] fade_rom [256];

  for (genvar c = 0; c < 256; c++) begin : g_fade
    localparam int COL_SAT = (c > HISTORY_COLUMNS - 1) ? HISTORY_COLUMNS - 1 : c;
    localparam logic [16:0] FADE_VAL =
      17'(65536 - (spec_cmap_pkg::FADE_SPAN_Q16 * COL_SAT) / (HISTORY_COLUMNS - 1));
    assign fade_rom[c] = FADE_VAL;
  end

  // pipeline control
  logic adv;

  assign adv        = !pixel_valid || !pixel_stall;
  assign cell_stall = div_busy || !adv;

  // stage 1: offset from floor, column gate, fade, flipped row
  logic [16:0] diff_s;
  logic        diff_pos;
  logic        col_ok;
  logic [15:0] bins_eff;
  logic [15:0] bins_ext;

  logic        s1_valid;
  logic [15:0] s1_diff;
  logic [16:0] s1_fade;
  logic [15:0] s1_row;
  logic [7:0]  s1_column;

  assign diff_s   = {cell_payload.level_db[15], cell_payload.level_db} -
                    {floor_level[15], floor_level};
  assign diff_pos = !diff_s[16] && (diff_s != 17'd0);
  assign col_ok   = {1'b0, cell_payload.column} < valid_frames;
  assign bins_ext = {7'd0, bins_in_use};

  always_comb begin
    priority if (bins_in_use == 9'd0) begin
      bins_eff = 16'd1;
    end else if (bins_ext > BINS_W) begin
      bins_eff = BINS_W;
    end else begin
      bins_eff = bins_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cell_valid && !cell_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_diff   <= (col_ok && diff_pos) ? diff_s[15:0] : 16'd0;
      s1_fade   <= fade_rom[cell_payload.column];
      s1_row    <= bins_eff - 16'd1 - {8'd0, cell_payload.bin_row};
      s1_column <= cell_payload.column;
    end
  end

  // stage 2: scale by reciprocal, pixel index
  logic [31:0] row_prod;

  logic        s2_valid;
  logic [48:0] s2_prod;
  logic [16:0] s2_fade;
  logic [15:0] s2_index;

  assign row_prod = 32'(s1_row) * 32'(HIST_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod  <= 49'(s1_diff) * 49'(recip);
      s2_fade  <= s1_fade;
      s2_index <= row_prod[15:0] + {8'd0, s1_column};
    end
  end

  // stage 3: clamp to Q1.16 unity, optional inversion
  logic [32:0] norm_raw;
  logic [16:0] norm_sat;

  logic        s3_valid;
  logic [16:0] s3_norm;
  logic [16:0] s3_fade;
  logic [15:0] s3_index;

  assign norm_raw = s2_prod[48:16];
  assign norm_sat = (norm_raw > 33'(spec_cmap_pkg::ONE_Q16)) ? spec_cmap_pkg::ONE_Q16
                                                             : norm_raw[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_norm  <= (palette_select == spec_cmap_pkg::PAL_INVERT) ?
                  spec_cmap_pkg::ONE_Q16 - norm_sat : norm_sat;
      s3_fade  <= s2_fade;
      s3_index <= s2_index;
    end
  end

  // stage 4: gray level, heat segment and position within it
  logic [24:0] gray_acc;

  logic        s4_valid;
  logic        s4_heat;
  logic [1:0]  s4_seg;
  logic [16:0] s4_k;
  logic [7:0]  s4_gray;
  logic [16:0] s4_fade;
  logic [15:0] s4_index;

  assign gray_acc = ({s3_norm, 8'd0} - 25'(s3_norm)) + 25'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_heat  <= palette_select == spec_cmap_pkg::PAL_HEAT;
      s4_seg   <= s3_norm[16] ? spec_cmap_pkg::SEG_YELLOW : s3_norm[15:14];
      s4_k     <= s3_norm[16] ? spec_cmap_pkg::ONE_Q16 : {1'b0, s3_norm[13:0], 2'b00};
      s4_gray  <= gray_acc[23:16];
      s4_fade  <= s3_fade;
      s4_index <= s3_index;
    end
  end

  // stage 5: palette channels
  logic [16:0] k_rev;
  logic [24:0] up_acc;
  logic [24:0] down_acc;
  logic [7:0]  up;
  logic [7:0]  down;
  logic [7:0]  red_sel;
  logic [7:0]  green_sel;
  logic [7:0]  blue_sel;

  logic        s5_valid;
  logic [7:0]  s5_red;
  logic [7:0]  s5_green;
  logic [7:0]  s5_blue;
  logic [16:0] s5_fade;
  logic [15:0] s5_index;

  assign k_rev    = spec_cmap_pkg::ONE_Q16 - s4_k;
  assign up_acc   = {s4_k, 8'd0} - 25'(s4_k);
  assign down_acc = {k_rev, 8'd0} - 25'(k_rev);
  assign up       = up_acc[23:16];
  assign down     = down_acc[23:16];

  always_comb begin
    if (s4_heat) begin
      unique case (s4_seg)
        spec_cmap_pkg::SEG_BLUE: begin
          red_sel = 8'd0;   green_sel = up;     blue_sel = 8'd255;
        end
        spec_cmap_pkg::SEG_CYAN: begin
          red_sel = 8'd0;   green_sel = 8'd255; blue_sel = down;
        end
        spec_cmap_pkg::SEG_GREEN: begin
          red_sel = up;     green_sel = 8'd255; blue_sel = 8'd0;
        end
        default: begin
          red_sel = 8'd255; green_sel = down;   blue_sel = 8'd0;
        end
      endcase
    end else begin
      red_sel   = s4_gray;
      green_sel = s4_gray;
      blue_sel  = s4_gray;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_red   <= red_sel;
      s5_green <= green_sel;
      s5_blue  <= blue_sel;
      s5_fade  <= s4_fade;
      s5_index <= s4_index;
    end
  end

  // stage 6: age fade with rounding, output register
  logic [24:0] red_acc;
  logic [24:0] green_acc;
  logic [24:0] blue_acc;

  assign red_acc   = 25'(s5_red)   * 25'(s5_fade) + 25'd32768;
  assign green_acc = 25'(s5_green) * 25'(s5_fade) + 25'd32768;
  assign blue_acc  = 25'(s5_blue)  * 25'(s5_fade) + 25'd32768;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (adv) begin
      pixel_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel.red         <= red_acc[23:16];
      pixel.green       <= green_acc[23:16];
      pixel.blue        <= blue_acc[23:16];
      pixel.pixel_index <= s5_index;
    end
  end

  // checks
  `SCM_ASSERT_IMP(a_no_cell_during_div, div_run, cell_stall,
    "cell accepted while reciprocal in progress")
  `SCM_ASSERT_IMP(a_recip_low, $fell(div_run),
    (49'(recip) * 49'(div_r)) >= 49'h1_0000_0000, "reciprocal too small")
  `SCM_ASSERT_IMP(a_recip_high, $fell(div_run),
    ((49'(recip) * 49'(div_r)) - 49'(div_r)) < 49'h1_0000_0000, "reciprocal too large")
  `SCM_ASSERT_IMP(a_norm_range, s3_valid, s3_norm <= spec_cmap_pkg::ONE_Q16,
    "normalised level above unity")
  `SCM_ASSERT_NEXT(a_beat_reaches_out, s5_valid && adv, pixel_valid,
    "pipeline beat lost before output")

endmodule

`default_nettype wire
